@@ hw/rtl/sfa_pkg.sv @@
package sfa_pkg;

	localparam int SLOT_W = 5;
	localparam int SP_W   = 2;
	localparam int NSP_IN = 4;

	typedef enum logic [1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic CFG_NUM_SPECIES = 1'b0;
	localparam logic CFG_NUM_KPOINTS = 1'b1;

	typedef struct packed {
		logic              item_ld;
		logic [SLOT_W-1:0] slot;
		logic              sweep;
		logic              we;
		logic              wzero;
		logic              lat_x;
		logic [SP_W-1:0]   sel_x;
		logic              dens;
		logic              im;
		logic              mul1;
		logic [SP_W-1:0]   sel_y;
		logic              mul2;
		logic              dbl;
		logic              out_ld;
		logic              out_ok;
	} sfa_cmd_t;

	typedef struct packed {
		op_t               op;
		logic              k_ok;
		logic              slot_ok;
		logic [2:0]        ns;
		logic [SLOT_W-1:0] npair;
		logic [SLOT_W-1:0] nslots;
		logic [SLOT_W-1:0] rslot;
		logic              sweep_last;
		logic              out_free;
	} sfa_sts_t;

	// pair slot count for the species in use
	function automatic logic [SLOT_W-1:0] npair_f(input logic [2:0] ns);
		logic [SLOT_W-1:0] r;
		case (ns)
			3'd1:    r = 5'd1;
			3'd2:    r = 5'd3;
			3'd3:    r = 5'd6;
			3'd4:    r = 5'd10;
			default: r = 5'd1;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/species_structure_factor_accumulator.sv @@
// channel   dir  fields (low bit up)
// s_*       in   tuser: op[1:0]; tdata: weight, k_index, read_slot, re_s0..3, im_s0..3
// m_*       out  tdata: read_value[63:0]; tuser: slot_valid
// cfg_*     in   index 0 num_species, 1 num_kpoints; wdata 11 bits
// after reset the store is cleared one slot a cycle, all MAX_KPOINTS*ROW_SLOTS slots, s_tready low
// accumulate: a read-modify-write per slot in use, through ST_P0, ST_P1, ST_P2 and ST_WR
// clear: zeroes all ROW_SLOTS slots of the row; read: the slot goes into the output register once it is free
// one request in flight; a waiting result blocks only a following read, until the result is taken
module species_structure_factor_accumulator
	import sfa_pkg::*;
#(
	parameter int MAX_SPECIES = 4,
	parameter int MAX_KPOINTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [10:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // weight, k_index, read_slot, re_s0..re_s3, im_s0..im_s3
	input  logic [1:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // read_value
	output logic         m_tuser   // slot_valid
);
	localparam int ROW_SLOTS = (MAX_SPECIES * (MAX_SPECIES + 1)) / 2 + 2 * MAX_SPECIES;

	sfa_cmd_t cmd;
	sfa_sts_t sts;
	logic signed [15:0] re_in [NSP_IN];
	logic signed [15:0] im_in [NSP_IN];

	always_comb begin
		for (int s = 0; s < NSP_IN; s++) begin
			re_in[s] = s_tdata[31 + 16*s +: 16];
			im_in[s] = s_tdata[95 + 16*s +: 16];
		end
	end

	sfa_ctrl #(.ROW_SLOTS(ROW_SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfa_datapath #(
		.MAX_SPECIES (MAX_SPECIES),
		.MAX_KPOINTS (MAX_KPOINTS),
		.ROW_SLOTS   (ROW_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.op_in     (op_t'(s_tuser)),
		.weight_in (s_tdata[15:0]),
		.k_in      (s_tdata[25:16]),
		.slot_in   (s_tdata[30:26]),
		.re_in     (re_in),
		.im_in     (im_in),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule

@@ hw/rtl/sfa_ram.sv @@
module sfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/sfa_datapath.sv @@
module sfa_datapath
	import sfa_pkg::*;
#(
	parameter int MAX_SPECIES = 4,
	parameter int MAX_KPOINTS = 1024,
	parameter int ROW_SLOTS   = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_wdata,
	input  op_t                op_in,
	input  logic [15:0]        weight_in,
	input  logic [9:0]         k_in,
	input  logic [SLOT_W-1:0]  slot_in,
	input  logic signed [15:0] re_in [NSP_IN],
	input  logic signed [15:0] im_in [NSP_IN],
	input  sfa_cmd_t           cmd,
	output sfa_sts_t           sts,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,
	output logic               m_tuser
);
	localparam int DEPTH = MAX_KPOINTS * ROW_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_KPOINTS + 1);
	localparam int KC_W  = (KW > 11) ? KW : 11;

	logic [2:0]        ns_q;
	logic [10:0]       nk_q;
	op_t               op_q;
	logic [15:0]       w_q;
	logic [9:0]        k_q;
	logic [SLOT_W-1:0] rslot_q;
	logic signed [15:0] re_q [NSP_IN];
	logic signed [15:0] im_q [NSP_IN];
	logic [AW-1:0]     base_q;
	logic [AW-1:0]     sweep_q;
	logic signed [15:0] xre_q, xim_q;
	logic signed [31:0] pr_s1, pi_s1;
	logic signed [49:0] term_s2;
	logic              out_valid_q;
	logic [63:0]       out_data_q;
	logic              out_ok_q;

	logic [2:0]        ns_eff;
	logic [KC_W-1:0]   nk_eff;
	logic [AW-1:0]     addr;
	logic [63:0]       rdata, wdata;
	logic signed [15:0] yre, yim, xsel;
	logic signed [32:0] psum;
	logic signed [50:0] term;
	logic signed [64:0] s65;
	logic [63:0]       sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q <= 3'd4;
			nk_q <= 11'd1024;
		end else if (cfg_we) begin
			if (cfg_index == CFG_NUM_SPECIES) ns_q <= cfg_wdata[2:0];
			else nk_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (ns_q == 3'd0) ns_eff = 3'd1;
		else if (ns_q > 3'(MAX_SPECIES)) ns_eff = 3'(MAX_SPECIES);
		else ns_eff = ns_q;
		if (KC_W'(nk_q) > KC_W'(MAX_KPOINTS)) nk_eff = KC_W'(MAX_KPOINTS);
		else nk_eff = KC_W'(nk_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			op_q    <= op_in;
			w_q     <= weight_in;
			k_q     <= k_in;
			rslot_q <= slot_in;
			re_q    <= re_in;
			im_q    <= im_in;
			base_q  <= AW'(AW'(k_in) * AW'(ROW_SLOTS));
		end
		if (cmd.lat_x) begin
			xre_q <= re_q[cmd.sel_x];
			xim_q <= im_q[cmd.sel_x];
		end
		if (cmd.mul1) begin
			if (cmd.dens) begin
				pr_s1 <= 32'(xsel);
				pi_s1 <= '0;
			end else begin
				pr_s1 <= xre_q * yre;
				pi_s1 <= xim_q * yim;
			end
		end
		if (cmd.mul2) begin
			term_s2 <= psum * $signed({1'b0, w_q});
		end
		out_data_q <= cmd.out_ld ? (cmd.out_ok ? rdata : '0) : out_data_q;
		out_ok_q   <= cmd.out_ld ? cmd.out_ok : out_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep) sweep_q <= sweep_q + AW'(1);
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign yre  = re_q[cmd.sel_y];
	assign yim  = im_q[cmd.sel_y];
	assign xsel = cmd.im ? xim_q : xre_q;
	assign psum = 33'(pr_s1) + 33'(pi_s1);
	assign term = cmd.dbl ? (51'(term_s2) <<< 1) : 51'(term_s2);

	// saturate at signed 64 bits
	always_comb begin
		s65 = {rdata[63], rdata} + 65'(term);
		if (s65[64] != s65[63]) sat = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else sat = s65[63:0];
	end

	assign wdata = cmd.wzero ? '0 : sat;
	assign addr  = cmd.sweep ? sweep_q : base_q + AW'(cmd.slot);

	sfa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.addr  (addr),
		.we    (cmd.we),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_comb begin
		sts.op         = op_q;
		sts.k_ok       = KC_W'(k_q) < nk_eff;
		sts.ns         = ns_eff;
		sts.npair      = npair_f(ns_eff);
		sts.nslots     = npair_f(ns_eff) + SLOT_W'({ns_eff, 1'b0});
		sts.slot_ok    = rslot_q < sts.nslots;
		sts.rslot      = rslot_q;
		sts.sweep_last = sweep_q == AW'(DEPTH - 1);
		sts.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ok_q;
endmodule

@@ hw/rtl/sfa_ctrl.sv @@
module sfa_ctrl
	import sfa_pkg::*;
#(
	parameter int ROW_SLOTS = 18
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  sfa_sts_t sts,
	output sfa_cmd_t cmd
);
	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DEC, ST_P0, ST_P1, ST_P2, ST_WR, ST_CLR, ST_RD, ST_RDW
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SP_W-1:0]   i_q, j_q;
	logic              ok_q;

	logic              dens;
	logic [SLOT_W-1:0] doff;

	assign dens = slot_q >= sts.npair;
	assign doff = slot_q - sts.npair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			slot_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: if (sts.sweep_last) state_q <= ST_IDLE;
				ST_IDLE: if (s_tvalid) state_q <= ST_DEC;
				ST_DEC: begin
					slot_q <= '0;
					i_q    <= '0;
					j_q    <= '0;
					case (sts.op)
						OP_ACC:   state_q <= sts.k_ok ? ST_P0 : ST_IDLE;
						OP_CLEAR: state_q <= sts.k_ok ? ST_CLR : ST_IDLE;
						OP_READ: begin
							slot_q  <= sts.rslot;
							ok_q    <= sts.k_ok && sts.slot_ok;
							state_q <= (sts.k_ok && sts.slot_ok) ? ST_RD : ST_RDW;
						end
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_P0: state_q <= ST_P1;
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_WR;
				ST_WR: begin
					if (slot_q == sts.nslots - SLOT_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						slot_q  <= slot_q + SLOT_W'(1);
						state_q <= ST_P0;
						// next pair after (i, last) is (i+1, i+1)
						if (!dens) begin
							if (3'(j_q) == sts.ns - 3'd1) begin
								i_q <= i_q + SP_W'(1);
								j_q <= i_q + SP_W'(1);
							end else begin
								j_q <= j_q + SP_W'(1);
							end
						end
					end
				end
				ST_CLR: begin
					if (slot_q == SLOT_W'(ROW_SLOTS - 1)) state_q <= ST_IDLE;
					else slot_q <= slot_q + SLOT_W'(1);
				end
				ST_RD:  state_q <= ST_RDW;
				ST_RDW: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.slot    = slot_q;
		cmd.dens    = dens;
		cmd.im      = doff[0];
		cmd.sel_x   = dens ? doff[SP_W:1] : i_q;
		cmd.sel_y   = j_q;
		cmd.dbl     = !dens && (i_q != j_q);
		cmd.out_ok  = ok_q;
		s_tready    = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				cmd.we    = 1'b1;
				cmd.wzero = 1'b1;
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.item_ld = s_tvalid;
			end
			ST_P0:  cmd.lat_x = 1'b1;
			ST_P1:  cmd.mul1  = 1'b1;
			ST_P2:  cmd.mul2  = 1'b1;
			ST_WR:  cmd.we    = 1'b1;
			ST_CLR: begin
				cmd.we    = 1'b1;
				cmd.wzero = 1'b1;
			end
			ST_RDW: cmd.out_ld = sts.out_free;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_INIT |=> state_q != ST_INIT)
		else $error("init sweep re-entered");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result overwritten");
	a_row_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.we && !cmd.sweep) |-> slot_q < SLOT_W'(ROW_SLOTS))
		else $error("write outside row");
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.item_ld |=> state_q == ST_DEC)
		else $error("request not decoded");
`endif
endmodule

@@ tb/species_structure_factor_accumulator_tb.sv @@
module species_structure_factor_accumulator_tb;
	import sfa_pkg::*;

	typedef struct packed {
		op_t                op;
		logic [15:0]        weight;
		logic [9:0]         k_index;
		logic [4:0]         read_slot;
		logic [3:0][15:0]   re;
		logic [3:0][15:0]   im;
	} sample_t;

	typedef struct packed {
		logic [63:0] value;
		logic        ok;
	} readout_t;

	localparam int ROW_SLOTS = 18;
	localparam int NK = 1024;
	localparam longint LIMIT = 4000000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic         cfg_index = 0;
	logic [10:0]  cfg_wdata = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [159:0] s_tdata = 0;
	logic [1:0]   s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [63:0]  m_tdata;
	logic         m_tuser;

	species_structure_factor_accumulator dut (.*);

	always #6 clk = ~clk;

	// predictor state
	longint    slot_mem [NK*ROW_SLOTS];
	int        cur_species = 4;
	int        cur_kpoints = 1024;
	sample_t   pending_q [$];
	readout_t  expected_reads [$];
	int        mismatches = 0;
	longint    cycles = 0;
	bit        calm = 0;      // no idling stretch
	bit        hold_rx = 0;
	int        hold_count = 0;
	bit        done_in = 0;

	function automatic longint sat_sum(longint a, longint b);
		longint s;
		s = a + b;
		if (b > 0 && s < a) s = 64'sh7fffffffffffffff;
		if (b < 0 && s > a) s = 64'sh8000000000000000;
		return s;
	endfunction

	function automatic int pair_index(int a, int b, int ns);
		return ns*(ns-1)/2 - (ns-a)*(ns-a-1)/2 + b;
	endfunction

	// rebuild a request from the bus fields
	function automatic sample_t unpack_req(logic [1:0] u, logic [159:0] d);
		sample_t it;
		it.op        = op_t'(u);
		it.weight    = d[15:0];
		it.k_index   = d[25:16];
		it.read_slot = d[30:26];
		it.re        = d[94:31];
		it.im        = d[158:95];
		return it;
	endfunction

	task automatic predict(sample_t it);
		int ns, np, base, i, j;
		longint w, term;
		longint r [4];
		longint m [4];
		bit kok;
		readout_t ro;
		ns = (cur_species < 1) ? 1 : (cur_species > 4 ? 4 : cur_species);
		np = ns*(ns+1)/2;
		kok = it.k_index < ((cur_kpoints > NK) ? NK : cur_kpoints);
		base = it.k_index * ROW_SLOTS;
		w = it.weight;
		for (i = 0; i < 4; i++) begin
			r[i] = longint'(signed'(it.re[i]));
			m[i] = longint'(signed'(it.im[i]));
		end
		case (it.op)
			OP_ACC: if (kok) begin
				for (i = 0; i < ns; i++)
					for (j = i; j < ns; j++) begin
						term = w * (r[i]*r[j] + m[i]*m[j]);
						if (i != j) term = term * 2;
						slot_mem[base+pair_index(i, j, ns)] =
							sat_sum(slot_mem[base+pair_index(i, j, ns)], term);
					end
				for (i = 0; i < ns; i++) begin
					slot_mem[base+np+2*i] = sat_sum(slot_mem[base+np+2*i], w*r[i]);
					slot_mem[base+np+2*i+1] = sat_sum(slot_mem[base+np+2*i+1], w*m[i]);
				end
			end
			OP_CLEAR: if (kok)
				for (i = 0; i < ROW_SLOTS; i++) slot_mem[base+i] = 0;
			OP_READ: begin
				if (kok && it.read_slot < np + 2*ns) begin
					ro.value = slot_mem[base+it.read_slot];
					ro.ok = 1'b1;
				end else begin
					ro.value = '0;
					ro.ok = 1'b0;
				end
				expected_reads.push_back(ro);
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict(unpack_req(s_tuser, s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
					sample_t it;
					it = pending_q.pop_front();
					s_tuser <= it.op;
					s_tdata <= {1'b0, it.im, it.re, it.read_slot, it.k_index, it.weight};
					s_tvalid <= 1;
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			if (expected_reads.size() == 0) begin
				report("unexpected result", m_tdata, 64'd0);
			end else begin
				readout_t e;
				e = expected_reads.pop_front();
				if (m_tdata !== e.value) report("read_value", m_tdata, e.value);
				if (m_tuser !== e.ok) report("slot_valid", 64'(m_tuser), 64'(e.ok));
			end
		end
		if (hold_count > 0) begin
			hold_count--;
			m_tready <= 0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 22);
		end
	end

	function automatic sample_t rnd_item(bit sane);
		sample_t it;
		int r;
		r = $urandom_range(99);
		it.op = r < 50 ? OP_ACC : r < 85 ? OP_READ : r < 95 ? OP_CLEAR : OP_NONE;
		it.weight = 16'($urandom);
		it.k_index = sane ? 10'($urandom_range(7)) : 10'($urandom);
		it.read_slot = sane ? 5'($urandom_range(17)) : 5'($urandom);
		for (int i = 0; i < 4; i++) begin
			it.re[i] = 16'($urandom);
			it.im[i] = 16'($urandom);
		end
		if ($urandom_range(9) == 0) begin
			it.weight = 16'hffff;
			for (int i = 0; i < 4; i++) begin
				it.re[i] = 16'h8000;
				it.im[i] = 16'h8000;
			end
		end
		return it;
	endfunction

	function automatic sample_t mk(op_t op, int k, int slot, bit [15:0] w, bit [15:0] v);
		sample_t it;
		it.op = op;
		it.weight = w;
		it.k_index = 10'(k);
		it.read_slot = 5'(slot);
		for (int i = 0; i < 4; i++) begin
			it.re[i] = v;
			it.im[i] = ~v;
		end
		return it;
	endfunction

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || expected_reads.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, int val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= 11'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_NUM_SPECIES) cur_species = val & 7;
		else cur_kpoints = val & 11'h7ff;
	endtask

	initial begin
		int sp [6];
		int kp [6];
		foreach (slot_mem[i]) slot_mem[i] = 0;
		sp = '{4, 1, 2, 3, 0, 7};
		kp = '{1024, 1, 8, 2047, 0, 5};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, every op, out of range cases
		pending_q.push_back(mk(OP_ACC, 0, 0, 16'hffff, 16'h8000));
		pending_q.push_back(mk(OP_ACC, 0, 0, 16'hffff, 16'h7fff));
		pending_q.push_back(mk(OP_ACC, 1023, 0, 16'h1000, 16'h0100));
		pending_q.push_back(mk(OP_ACC, 3, 0, 0, 16'h1234));
		for (int s = 0; s < 20; s += 3) pending_q.push_back(mk(OP_READ, 0, s, 0, 0));
		pending_q.push_back(mk(OP_READ, 1023, 17, 0, 0));
		pending_q.push_back(mk(OP_READ, 5, 31, 0, 0));
		pending_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
		pending_q.push_back(mk(OP_READ, 0, 0, 0, 0));
		pending_q.push_back(mk(OP_NONE, 0, 0, 16'hffff, 16'hffff));
		pending_q.push_back(mk(OP_READ, 1023, 10, 0, 0));
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(CFG_NUM_SPECIES, sp[ph]);
			write_cfg(CFG_NUM_KPOINTS, kp[ph]);
			calm = (ph == 2);
			for (int n = 0; n < 170; n++) begin
				pending_q.push_back(rnd_item($urandom_range(9) != 0));
				if (ph == 1 && n == 60) begin
					// long receiver hold-off while requests keep coming
					while (pending_q.size() > 0) @(posedge clk);
					hold_count = 400;
					for (int q = 0; q < 20; q++)
						pending_q.push_back(mk(OP_READ, 0, q % 18, 0, 0));
				end
				if (ph == 3 && n == 80) drain();
			end
			drain();
		end
		if (mismatches == 0 && expected_reads.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_ram.sv
hw/rtl/sfa_datapath.sv
hw/rtl/sfa_ctrl.sv
hw/rtl/species_structure_factor_accumulator.sv
tb/species_structure_factor_accumulator_tb.sv
